@@ design/paf_pkg.sv @@
package paf_pkg;

   localparam logic [1:0] CMD_OFFER = 2'd0;
   localparam logic [1:0] CMD_TRIM  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [2:0] ST_ACCEPTED  = 3'd0;
   localparam logic [2:0] ST_DOMINATED = 3'd1;
   localparam logic [2:0] ST_OVERFLOW  = 3'd2;
   localparam logic [2:0] ST_TRIMMED   = 3'd3;
   localparam logic [2:0] ST_NO_TRIM   = 3'd4;
   localparam logic [2:0] ST_READ_OK   = 3'd5;
   localparam logic [2:0] ST_BAD_INDEX = 3'd6;

   localparam logic CSR_NUM_OBJECTIVES = 1'b0;
   localparam logic CSR_ARCHIVE_LIMIT  = 1'b1;

   localparam int ERR_WIDTH  = 32;
   localparam int NUM_IN_ERR = 4;

   typedef enum logic [3:0] {
      S_IDLE, S_CHK_A, S_CHK_B, S_CMP_A, S_CMP_B, S_APPEND,
      S_TRIM_IDX, S_TRIM_R, S_TRIM_E, S_TRIM_A, S_TRIM_B, S_TRIM_END,
      S_RD_A, S_RD_B, S_FINISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_CHECK, OP_RESTART, OP_COMPACT, OP_APPEND,
      OP_TRIM_IDX, OP_CAPTURE, OP_SHIFT, OP_SHRINK, OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      addr_next;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       scan_done;
      logic       shift_done;
      logic       dominated;
      logic       trim_ok;
      logic       read_ok;
      logic       rsp_busy;
   } dp_status_type;

endpackage

@@ design/paf_ctrl.sv @@
module paf_ctrl
   import paf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_FINISH;
               if (status.cmd == CMD_OFFER) state_in = S_CHK_A;
               if (status.cmd == CMD_TRIM)  state_in = S_TRIM_IDX;
               if (status.cmd == CMD_READ)  state_in = S_RD_A;
            end
         end
         S_CHK_A: begin
            if (status.dominated)      state_in = S_FINISH;
            else if (status.scan_done) state_in = S_CMP_A;
            else                       state_in = S_CHK_B;
         end
         S_CHK_B:    state_in = S_CHK_A;
         S_CMP_A:    state_in = status.scan_done ? S_APPEND : S_CMP_B;
         S_CMP_B:    state_in = S_CMP_A;
         S_APPEND:   state_in = S_FINISH;
         S_TRIM_IDX: state_in = status.trim_ok ? S_TRIM_R : S_FINISH;
         S_TRIM_R:   state_in = S_TRIM_E;
         S_TRIM_E:   state_in = S_TRIM_A;
         S_TRIM_A:   state_in = status.shift_done ? S_TRIM_END : S_TRIM_B;
         S_TRIM_B:   state_in = S_TRIM_A;
         S_TRIM_END: state_in = S_FINISH;
         S_RD_A:     state_in = status.read_ok ? S_RD_B : S_FINISH;
         S_RD_B:     state_in = S_FINISH;
         S_FINISH:   state_in = status.rsp_busy ? S_FINISH : S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl.op        = OP_NONE;
      ctrl.addr_next = 1'b0;
      req_stall      = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) ctrl.op = OP_LATCH;
         end
         S_CHK_A: begin
            if (status.scan_done) ctrl.op = OP_RESTART;
         end
         S_CHK_B:    ctrl.op = OP_CHECK;
         S_CMP_B:    ctrl.op = OP_COMPACT;
         S_APPEND:   ctrl.op = OP_APPEND;
         S_TRIM_IDX: ctrl.op = OP_TRIM_IDX;
         S_TRIM_E:   ctrl.op = OP_CAPTURE;
         S_TRIM_A:   ctrl.addr_next = 1'b1;
         S_TRIM_B:   ctrl.op = OP_SHIFT;
         S_TRIM_END: ctrl.op = OP_SHRINK;
         S_RD_B:     ctrl.op = OP_CAPTURE;
         S_FINISH: begin
            if (!status.rsp_busy) ctrl.op = OP_FINISH;
         end
         default: ctrl.op = OP_NONE;
      endcase
   end

endmodule

@@ design/paf_datapath.sv @@
module paf_datapath
   import paf_pkg::*;
#(
   parameter int ARCHIVE_DEPTH  = 64,
   parameter int MAX_OBJECTIVES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [6:0]           csr_data,
   input  logic [1:0]           req_command,
   input  logic [15:0]          req_cand_tag,
   input  logic signed [31:0]   req_cand_err0,
   input  logic signed [31:0]   req_cand_err1,
   input  logic signed [31:0]   req_cand_err2,
   input  logic signed [31:0]   req_cand_err3,
   input  logic [15:0]          req_random_value,
   input  logic [5:0]           req_read_index,
   input  ctrl_cmd_type         ctrl,
   output dp_status_type        status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [6:0]           rsp_removed_count,
   output logic [6:0]           rsp_archive_count,
   output logic [15:0]          rsp_entry_tag,
   output logic signed [31:0]   rsp_entry_err0,
   output logic signed [31:0]   rsp_entry_err1,
   output logic signed [31:0]   rsp_entry_err2,
   output logic signed [31:0]   rsp_entry_err3
);

   localparam int AW = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
   localparam int CW = $clog2(ARCHIVE_DEPTH + 1);
   localparam int LW = (CW > 7) ? CW : 7;
   localparam int IW = (CW > 6) ? CW : 6;
   localparam int EW = MAX_OBJECTIVES * ERR_WIDTH;
   localparam int PW = 16 + CW;

   logic [15:0] mem_tag [ARCHIVE_DEPTH];
   logic [EW-1:0] mem_err [ARCHIVE_DEPTH];

   logic [2:0]    num_obj_ff;
   logic [6:0]    limit_ff;
   logic [1:0]    cmd_ff;
   logic [15:0]   tag_ff;
   logic [EW-1:0] cand_ff, cand_in;
   logic [15:0]   rand_ff;
   logic [CW-1:0] size_ff, i_ff, w_ff, removed_ff;
   logic          dom_ff, full_ff, ok_ff, rd_range_ff;
   logic [15:0]   rd_tag_ff;
   logic [EW-1:0] rd_err_ff;
   logic [15:0]   ent_tag_ff;
   logic [31:0]   ent_err_ff [NUM_IN_ERR];
   logic [31:0]   rd_err_ext [NUM_IN_ERR];
   logic          rsp_valid_ff;
   logic [2:0]    rsp_status_ff;
   logic [6:0]    rsp_removed_ff, rsp_count_ff;
   logic [15:0]   rsp_tag_ff;
   logic [31:0]   rsp_err_ff [NUM_IN_ERR];

   logic [AW-1:0] rd_addr;
   logic [3:0]    n_act;
   logic [PW-1:0] prod;
   logic          entry_dom_cand, cand_dom_entry;
   logic [31:0]   req_err [NUM_IN_ERR];

   assign req_err[0] = req_cand_err0;
   assign req_err[1] = req_cand_err1;
   assign req_err[2] = req_cand_err2;
   assign req_err[3] = req_cand_err3;

   for (genvar k = 0; k < MAX_OBJECTIVES; k++) begin : g_cand
      if (k < NUM_IN_ERR) begin : g_in
         assign cand_in[k*ERR_WIDTH +: ERR_WIDTH] = req_err[k];
      end else begin : g_zero
         assign cand_in[k*ERR_WIDTH +: ERR_WIDTH] = '0;
      end
   end

   for (genvar k = 0; k < NUM_IN_ERR; k++) begin : g_ext
      if (k < MAX_OBJECTIVES) begin : g_in
         assign rd_err_ext[k] = rd_err_ff[k*ERR_WIDTH +: ERR_WIDTH];
      end else begin : g_zero
         assign rd_err_ext[k] = '0;
      end
   end

   always_comb begin
      if (num_obj_ff == 3'd0) begin
         n_act = 4'd1;
      end else if (int'(num_obj_ff) > MAX_OBJECTIVES) begin
         n_act = 4'(MAX_OBJECTIVES);
      end else begin
         n_act = {1'b0, num_obj_ff};
      end
   end

   function automatic logic dominates(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                      input logic [3:0] n);
      logic worse;
      logic better;
      worse  = 1'b0;
      better = 1'b0;
      for (int k = 0; k < MAX_OBJECTIVES; k++) begin
         if (k < int'(n)) begin
            if ($signed(a[k*ERR_WIDTH +: ERR_WIDTH]) > $signed(b[k*ERR_WIDTH +: ERR_WIDTH]))
               worse = 1'b1;
            if ($signed(a[k*ERR_WIDTH +: ERR_WIDTH]) < $signed(b[k*ERR_WIDTH +: ERR_WIDTH]))
               better = 1'b1;
         end
      end
      return better && !worse;
   endfunction

   assign entry_dom_cand = dominates(rd_err_ff, cand_ff, n_act);
   assign cand_dom_entry = dominates(cand_ff, rd_err_ff, n_act);
   assign rd_addr = ctrl.addr_next ? AW'(i_ff + CW'(1)) : AW'(i_ff);
   assign prod = PW'(rand_ff) * PW'(size_ff);

   // archive memory: at most one write and one registered read per cycle
   always_ff @(posedge clock) begin
      rd_tag_ff <= mem_tag[rd_addr];
      rd_err_ff <= mem_err[rd_addr];
      if (ctrl.op == OP_COMPACT && !cand_dom_entry) begin
         mem_tag[AW'(w_ff)] <= rd_tag_ff;
         mem_err[AW'(w_ff)] <= rd_err_ff;
      end else if (ctrl.op == OP_SHIFT) begin
         mem_tag[AW'(i_ff)] <= rd_tag_ff;
         mem_err[AW'(i_ff)] <= rd_err_ff;
      end else if (ctrl.op == OP_APPEND && int'(w_ff) < ARCHIVE_DEPTH) begin
         mem_tag[AW'(w_ff)] <= tag_ff;
         mem_err[AW'(w_ff)] <= cand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_obj_ff <= 3'd2;
         limit_ff   <= 7'd10;
      end else if (csr_write) begin
         if (csr_index == CSR_NUM_OBJECTIVES) num_obj_ff <= csr_data[2:0];
         if (csr_index == CSR_ARCHIVE_LIMIT)  limit_ff   <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.op == OP_FINISH)            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (ctrl.op)
            OP_APPEND: begin
               size_ff <= (int'(w_ff) < ARCHIVE_DEPTH) ? w_ff + CW'(1) : w_ff;
            end
            OP_SHRINK: size_ff <= size_ff - CW'(1);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_LATCH: begin
            cmd_ff      <= req_command;
            tag_ff      <= req_cand_tag;
            cand_ff     <= cand_in;
            rand_ff     <= req_random_value;
            i_ff        <= (req_command == CMD_READ) ? CW'(req_read_index) : '0;
            rd_range_ff <= IW'(req_read_index) < IW'(size_ff);
            w_ff        <= '0;
            removed_ff  <= '0;
            dom_ff      <= 1'b0;
            full_ff     <= 1'b0;
            ok_ff       <= 1'b0;
            ent_tag_ff  <= '0;
            for (int k = 0; k < NUM_IN_ERR; k++) ent_err_ff[k] <= '0;
         end
         OP_CHECK: begin
            if (entry_dom_cand) dom_ff <= 1'b1;
            i_ff <= i_ff + CW'(1);
         end
         OP_RESTART: i_ff <= '0;
         OP_COMPACT: begin
            if (cand_dom_entry) removed_ff <= removed_ff + CW'(1);
            else                w_ff       <= w_ff + CW'(1);
            i_ff <= i_ff + CW'(1);
         end
         OP_APPEND: full_ff <= int'(w_ff) >= ARCHIVE_DEPTH;
         OP_TRIM_IDX: i_ff <= prod[PW-1:16];
         OP_CAPTURE: begin
            ok_ff      <= 1'b1;
            ent_tag_ff <= rd_tag_ff;
            for (int k = 0; k < NUM_IN_ERR; k++) ent_err_ff[k] <= rd_err_ext[k];
         end
         OP_SHIFT: i_ff <= i_ff + CW'(1);
         OP_FINISH: begin
            rsp_count_ff   <= 7'(size_ff);
            rsp_tag_ff     <= ent_tag_ff;
            for (int k = 0; k < NUM_IN_ERR; k++) rsp_err_ff[k] <= ent_err_ff[k];
            case (cmd_ff)
               CMD_OFFER: begin
                  rsp_removed_ff <= 7'(removed_ff);
                  if (dom_ff)       rsp_status_ff <= ST_DOMINATED;
                  else if (full_ff) rsp_status_ff <= ST_OVERFLOW;
                  else              rsp_status_ff <= ST_ACCEPTED;
               end
               CMD_TRIM: begin
                  rsp_removed_ff <= {6'd0, ok_ff};
                  rsp_status_ff  <= ok_ff ? ST_TRIMMED : ST_NO_TRIM;
               end
               CMD_READ: begin
                  rsp_removed_ff <= '0;
                  rsp_status_ff  <= ok_ff ? ST_READ_OK : ST_BAD_INDEX;
               end
               default: begin
                  rsp_removed_ff <= '0;
                  rsp_status_ff  <= ST_BAD_INDEX;
               end
            endcase
         end
         default: ;
      endcase
   end

   assign status.cmd        = (ctrl.op == OP_LATCH) ? req_command : cmd_ff;
   assign status.scan_done  = i_ff >= size_ff;
   assign status.shift_done = (i_ff + CW'(1)) >= size_ff;
   assign status.dominated  = dom_ff;
   assign status.trim_ok    = LW'(size_ff) > LW'(limit_ff);
   assign status.read_ok    = rd_range_ff;
   assign status.rsp_busy   = rsp_valid_ff && rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_archive_count = rsp_count_ff;
   assign rsp_entry_tag     = rsp_tag_ff;
   assign rsp_entry_err0    = rsp_err_ff[0];
   assign rsp_entry_err1    = rsp_err_ff[1];
   assign rsp_entry_err2    = rsp_err_ff[2];
   assign rsp_entry_err3    = rsp_err_ff[3];

endmodule

@@ design/pareto_archive_filter_top.sv @@
// pareto archive filter: keeps an ordered archive of non-dominated candidates
// req_ channel: one command word (offer, trim, read) with candidate fields
// rsp_ channel: one result word per command (status, counts, entry fields)
// csr_ port: csr_write with csr_index 0 num_objectives, 1 archive_limit
// one command is worked on at a time, entries streamed through one read and one write port
// offer: a dominance scan over the archive, a compaction that drops the entries it dominates, then the append
// offer rejected as dominated: stops the scan early, once an entry that dominates it is found
// trim: if the count exceeds archive_limit, captures the picked entry and shifts the later ones down
// read: captures the entry at the index; a bad index or an unused command skips the capture
// the next word is taken in the cycle after the result register loads
// reset clears the count and rsp_valid and restores the csr defaults; memory contents need no clearing
// while rsp_stall is high the result holds and the next word waits in finish
module pareto_archive_filter_top
   import paf_pkg::*;
#(
   parameter int ARCHIVE_DEPTH  = 64,
   parameter int MAX_OBJECTIVES = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [6:0]         csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [15:0]        req_cand_tag,
   input  logic signed [31:0] req_cand_err0,
   input  logic signed [31:0] req_cand_err1,
   input  logic signed [31:0] req_cand_err2,
   input  logic signed [31:0] req_cand_err3,
   input  logic [15:0]        req_random_value,
   input  logic [5:0]         req_read_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [6:0]         rsp_removed_count,
   output logic [6:0]         rsp_archive_count,
   output logic [15:0]        rsp_entry_tag,
   output logic signed [31:0] rsp_entry_err0,
   output logic signed [31:0] rsp_entry_err1,
   output logic signed [31:0] rsp_entry_err2,
   output logic signed [31:0] rsp_entry_err3
);

   ctrl_cmd_type  ctrl;
   dp_status_type status;

   paf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   paf_datapath #(
      .ARCHIVE_DEPTH  (ARCHIVE_DEPTH),
      .MAX_OBJECTIVES (MAX_OBJECTIVES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_command       (req_command),
      .req_cand_tag      (req_cand_tag),
      .req_cand_err0     (req_cand_err0),
      .req_cand_err1     (req_cand_err1),
      .req_cand_err2     (req_cand_err2),
      .req_cand_err3     (req_cand_err3),
      .req_random_value  (req_random_value),
      .req_read_index    (req_read_index),
      .ctrl              (ctrl),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_count (rsp_removed_count),
      .rsp_archive_count (rsp_archive_count),
      .rsp_entry_tag     (rsp_entry_tag),
      .rsp_entry_err0    (rsp_entry_err0),
      .rsp_entry_err1    (rsp_entry_err1),
      .rsp_entry_err2    (rsp_entry_err2),
      .rsp_entry_err3    (rsp_entry_err3)
   );

endmodule
